// ===== hdl/text_console_character_engine_unit_macros.svh =====
// Assertion macros used by the console engine top level.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tcce_pkg.sv =====
// Package with the request and result types, codes and constants of the console engine.
`timescale 1ns / 1ps

package tcce_pkg;

    // Default screen geometry and tab spacing.
    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int TAB_STOP_DEF    = 8;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Attribute after reset: white on black.
    localparam logic [7:0] TEXT_ATTR_RESET = 8'h0F;

    // Cell width (character in the lower byte, attribute in the upper byte).
    localparam int CELL_W = 16;

    // Control characters and the blank character.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Operation codes of a request.
    typedef enum logic [2:0] {
        OP_PUT_CHAR     = 3'd0,
        OP_CLEAR        = 3'd1,
        OP_SET_POSITION = 3'd2,
        OP_WRITE_AT     = 3'd3,
        OP_READ_CELL    = 3'd4
    } t_op;

    // Work kinds after classification in the front part.
    typedef enum logic [3:0] {
        K_NOP       = 4'd0,
        K_NEWLINE   = 4'd1,
        K_RETURN    = 4'd2,
        K_BACKSPACE = 4'd3,
        K_TAB       = 4'd4,
        K_PRINT     = 4'd5,
        K_CLEAR     = 4'd6,
        K_SETPOS    = 4'd7,
        K_WRITE     = 4'd8,
        K_READ      = 4'd9
    } t_cmd_kind;

    // One input request.
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] cell_attr;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_offset;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic        scrolled;
    } t_out_item;

    // Classified command with the position already clamped to the screen.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] cell_attr;
    } t_cmd;

endpackage

// ===== hdl/text_console_character_engine_unit.sv =====
// Top level of the text console engine: front, command queue, back and attribute register.
//
// Requests arrive on i_valid/o_ready with a t_in_item payload; each request gives
// exactly one result on o_valid/i_ready with a t_out_item payload, in request order.
// The attribute register is written through i_cfg_valid/o_cfg_ready/i_cfg_data,
// which is always ready and should only be used while the engine is idle.
// The back sequencer takes a simple request from the queue, executes it and then
// loads the result register once that register is free; read_cell passes through a
// read state first. A put_char that scrolls, and a clear, first sweep the screen
// store one cell per cycle through its single write port. The back sequencer takes
// no new request from the queue until the result of the one before has been loaded.
// The front keeps taking requests into a two-entry queue while the back works or a
// result waits; when the receiver stalls, the result register holds and the queue
// fills, after which o_ready drops.
// Reset (synchronous, active low) homes the cursor, empties the queue and the result
// register, and sets the attribute to 0x0F. Screen cells are undefined until written.
`timescale 1ns / 1ps

`include "text_console_character_engine_unit_macros.svh"

module text_console_character_engine_unit #(
    parameter int SCREEN_COLS = tcce_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcce_pkg::SCREEN_ROWS_DEF,
    parameter int TAB_STOP    = tcce_pkg::TAB_STOP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tcce_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output tcce_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    localparam logic [31:0] LAST_ROW32 = 32'(SCREEN_ROWS - 1);

    logic           cfg_we;
    logic [7:0]     r_text_attr;
    logic           q_full;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    tcce_pkg::t_cmd front_cmd;
    tcce_pkg::t_cmd back_cmd;

    // Attribute register.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= tcce_pkg::TEXT_ATTR_RESET;
        end else if (cfg_we) begin
            r_text_attr <= i_cfg_data;
        end
    end

    // Front part: request intake and classification.
    tcce_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // Command queue.
    tcce_queue #(
        .DEPTH (tcce_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd)
    );

    // Back part: execution and results.
    tcce_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .TAB_STOP    (TAB_STOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

    // A scroll always leaves the cursor on the bottom row.
    `TCCE_ASSERT_IMPL(a_scroll_bottom_row, i_clk, i_rst_n, o_valid && o_item.scrolled, o_item.cursor_row == LAST_ROW32[4:0], "scroll result not on bottom row")
    // A scrolling put_char never carries read data.
    `TCCE_ASSERT_IMPL(a_scroll_no_read, i_clk, i_rst_n, o_valid && o_item.scrolled, (o_item.read_char == 8'h00) && (o_item.read_attr == 8'h00), "scroll result carries read data")
    // The reported column stays on the screen.
    `TCCE_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, o_valid, 32'(o_item.cursor_col) < 32'(SCREEN_COLS), "cursor column off screen")
    // A configuration write lands in the attribute register.
    `TCCE_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, cfg_we, r_text_attr == $past(i_cfg_data), "attribute write lost")

endmodule

// ===== hdl/tcce_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcce_front.sv =====
// Front part: accepts requests, clamps positions and classifies the work.
`timescale 1ns / 1ps

module tcce_front #(
    parameter int SCREEN_COLS = tcce_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcce_pkg::SCREEN_ROWS_DEF
) (
    input  logic               i_valid,
    output logic               o_ready,
    input  tcce_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_push,
    output tcce_pkg::t_cmd     o_cmd
);

    logic [31:0] row32;
    logic [31:0] col32;
    logic [31:0] last_row32;
    logic [31:0] last_col32;

    // A request is taken whenever the queue has room.
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Clamp the position; the clamped value never exceeds the field value.
    always_comb begin
        row32      = 32'(i_item.row);
        col32      = 32'(i_item.col);
        last_row32 = 32'(SCREEN_ROWS - 1);
        last_col32 = 32'(SCREEN_COLS - 1);
        if (row32 > last_row32) begin
            row32 = last_row32;
        end
        if (col32 > last_col32) begin
            col32 = last_col32;
        end
    end

    // Classify the request into one kind of work for the back part.
    always_comb begin
        o_cmd.char_code = i_item.char_code;
        o_cmd.row       = row32[4:0];
        o_cmd.col       = col32[6:0];
        o_cmd.cell_attr = i_item.cell_attr;
        case (i_item.operation)
            tcce_pkg::OP_PUT_CHAR: begin
                case (i_item.char_code)
                    tcce_pkg::CH_NEWLINE:   o_cmd.kind = tcce_pkg::K_NEWLINE;
                    tcce_pkg::CH_RETURN:    o_cmd.kind = tcce_pkg::K_RETURN;
                    tcce_pkg::CH_BACKSPACE: o_cmd.kind = tcce_pkg::K_BACKSPACE;
                    tcce_pkg::CH_TAB:       o_cmd.kind = tcce_pkg::K_TAB;
                    default:                o_cmd.kind = tcce_pkg::K_PRINT;
                endcase
            end
            tcce_pkg::OP_CLEAR:        o_cmd.kind = tcce_pkg::K_CLEAR;
            tcce_pkg::OP_SET_POSITION: o_cmd.kind = tcce_pkg::K_SETPOS;
            tcce_pkg::OP_WRITE_AT:     o_cmd.kind = tcce_pkg::K_WRITE;
            tcce_pkg::OP_READ_CELL:    o_cmd.kind = tcce_pkg::K_READ;
            default:                   o_cmd.kind = tcce_pkg::K_NOP;
        endcase
    end

endmodule

// ===== hdl/tcce_queue.sv =====
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module tcce_queue #(
    parameter int DEPTH = tcce_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcce_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output tcce_pkg::t_cmd o_cmd
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tcce_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wp;
    logic [AW-1:0]  n_rp;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== hdl/tcce_back.sv =====
// Back part: cursor, screen store sequencing (scroll, clear) and the result register.
`timescale 1ns / 1ps

module tcce_back #(
    parameter int SCREEN_COLS = tcce_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcce_pkg::SCREEN_ROWS_DEF,
    parameter int TAB_STOP    = tcce_pkg::TAB_STOP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_text_attr,
    input  logic                i_q_valid,
    input  tcce_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output tcce_pkg::t_out_item o_item
);

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int MOVE  = CELLS - SCREEN_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int TW    = $clog2(SCREEN_COLS + TAB_STOP + 1);
    localparam int NSTOP = (SCREEN_COLS + TAB_STOP - 1) / TAB_STOP;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_FILL   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       n_row;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       n_col;
    logic [CNTW-1:0]     r_cnt;
    logic [CNTW-1:0]     n_cnt;
    logic [AW-1:0]       r_wa;
    logic [AW-1:0]       n_wa;
    logic                r_pend;
    logic                n_pend;
    logic                r_scrolled;
    logic                n_scrolled;
    logic [7:0]          r_rd_char;
    logic [7:0]          n_rd_char;
    logic [7:0]          r_rd_attr;
    logic [7:0]          n_rd_attr;
    logic                r_out_valid;
    logic                n_out_valid;
    tcce_pkg::t_out_item r_out_item;
    tcce_pkg::t_out_item n_out_item;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [tcce_pkg::CELL_W-1:0]   mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [tcce_pkg::CELL_W-1:0]   mem_rdata;

    logic [31:0]   cmd_row32;
    logic [31:0]   cmd_col32;
    logic [31:0]   cur_addr32;
    logic [31:0]   cmd_addr32;
    logic [31:0]   src32;
    logic [31:0]   off32;
    logic [31:0]   row_out32;
    logic [31:0]   col_out32;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] cmd_addr;
    logic [TW-1:0] tab_stop;
    logic          last_col;
    logic          last_row;
    logic          advance;
    logic [15:0]   blank;

    // Smallest tab stop beyond the given column.
    function automatic logic [TW-1:0] f_next_tab(input logic [CW-1:0] col);
        logic [TW-1:0] stop;
        stop = TW'(NSTOP * TAB_STOP);
        for (int k = NSTOP; k >= 1; k--) begin
            if (32'(k * TAB_STOP) > 32'(col)) begin
                stop = TW'(k * TAB_STOP);
            end
        end
        return stop;
    endfunction

    // Addresses and cursor conditions.
    always_comb begin
        cmd_row32  = 32'(i_cmd.row);
        cmd_col32  = 32'(i_cmd.col);
        cur_addr32 = 32'(r_row) * 32'(SCREEN_COLS) + 32'(r_col);
        cmd_addr32 = cmd_row32 * 32'(SCREEN_COLS) + cmd_col32;
        src32      = 32'(r_cnt) + 32'(SCREEN_COLS);
        cur_addr   = cur_addr32[AW-1:0];
        cmd_addr   = cmd_addr32[AW-1:0];
        tab_stop   = f_next_tab(r_col);
        last_col   = (32'(r_col) == 32'(SCREEN_COLS - 1));
        last_row   = (32'(r_row) == 32'(SCREEN_ROWS - 1));
        blank      = {i_text_attr, tcce_pkg::CH_SPACE};
    end

    // Result fields from the cursor as it stands after the work.
    always_comb begin
        off32     = 32'(r_row) * 32'(SCREEN_COLS) + 32'(r_col);
        row_out32 = 32'(r_row);
        col_out32 = 32'(r_col);
    end

    // Sequencer: one pass in idle for simple work, sweeps for scroll and clear.
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_wa        = r_wa;
        n_pend      = r_pend;
        n_scrolled  = r_scrolled;
        n_rd_char   = r_rd_char;
        n_rd_attr   = r_rd_attr;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        mem_we      = 1'b0;
        mem_waddr   = cur_addr;
        mem_wdata   = blank;
        mem_re      = 1'b0;
        mem_raddr   = cmd_addr;
        o_pop       = 1'b0;
        advance     = 1'b0;

        // The receiver taking the result frees the output register.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop      = 1'b1;
                    n_state    = S_DONE;
                    n_scrolled = 1'b0;
                    n_rd_char  = '0;
                    n_rd_attr  = '0;
                    case (i_cmd.kind)
                        tcce_pkg::K_NEWLINE: begin
                            n_col   = '0;
                            advance = 1'b1;
                        end
                        tcce_pkg::K_RETURN: begin
                            n_col = '0;
                        end
                        tcce_pkg::K_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col     = r_col - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr - 1'b1;
                            end
                        end
                        tcce_pkg::K_TAB: begin
                            if (32'(tab_stop) >= 32'(SCREEN_COLS)) begin
                                n_col   = '0;
                                advance = 1'b1;
                            end else begin
                                n_col = tab_stop[CW-1:0];
                            end
                        end
                        tcce_pkg::K_PRINT: begin
                            mem_we    = 1'b1;
                            mem_wdata = {i_text_attr, i_cmd.char_code};
                            if (last_col) begin
                                n_col   = '0;
                                advance = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tcce_pkg::K_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        tcce_pkg::K_SETPOS: begin
                            n_row = cmd_row32[RW-1:0];
                            n_col = cmd_col32[CW-1:0];
                        end
                        tcce_pkg::K_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = cmd_addr;
                            mem_wdata = {i_cmd.cell_attr, i_cmd.char_code};
                        end
                        tcce_pkg::K_READ: begin
                            mem_re  = 1'b1;
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                    // Moving past the bottom row scrolls and keeps the cursor there.
                    if (advance) begin
                        if (last_row) begin
                            n_scrolled = 1'b1;
                            n_cnt      = '0;
                            n_pend     = 1'b0;
                            n_state    = S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_rd_char = mem_rdata[7:0];
                n_rd_attr = mem_rdata[15:8];
                n_state   = S_DONE;
            end
            S_SCROLL: begin
                // Read one line ahead and write back the cell read the cycle before.
                if (32'(r_cnt) < 32'(MOVE)) begin
                    mem_re    = 1'b1;
                    mem_raddr = src32[AW-1:0];
                    n_wa      = r_cnt[AW-1:0];
                    n_pend    = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FILL;
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wa;
                    mem_wdata = mem_rdata;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[AW-1:0];
                if (32'(r_cnt) == 32'(CELLS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_item.cursor_row      = row_out32[4:0];
                    n_out_item.cursor_col      = col_out32[6:0];
                    n_out_item.cursor_offset   = off32[10:0];
                    n_out_item.read_char       = r_rd_char;
                    n_out_item.read_attr       = r_rd_attr;
                    n_out_item.scrolled        = r_scrolled;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and sweep registers.
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_wa       <= n_wa;
        r_scrolled <= n_scrolled;
        r_rd_char  <= n_rd_char;
        r_rd_attr  <= n_rd_attr;
        r_out_item <= n_out_item;
    end

    // Screen store.
    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ===== tb/tb_text_console_character_engine_unit.sv =====
// Self-checking testbench for the text console engine: scoreboard predictor and random traffic.
`timescale 1ns / 1ps

module tb_text_console_character_engine_unit;

    localparam int COLS         = tcce_pkg::SCREEN_COLS_DEF;
    localparam int ROWS         = tcce_pkg::SCREEN_ROWS_DEF;
    localparam int TAB          = tcce_pkg::TAB_STOP_DEF;
    localparam int CELL_COUNT   = COLS * ROWS;
    localparam int MAX_GAP      = 14;
    localparam int SETTLE_WAIT  = 16;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 175;
    localparam int CYCLE_LIMIT  = 20_000_000;

    // Operation codes that the engine does not decode.
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    tcce_pkg::t_in_item  i_item;
    logic                o_valid;
    logic                i_ready;
    tcce_pkg::t_out_item o_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [7:0]          i_cfg_data;

    int cycle_count;
    int src_run;
    int sink_run;

    // Console predictor and result checker.
    class console_scoreboard;
        bit [15:0]           cells [CELL_COUNT];
        bit                  cell_written [CELL_COUNT];
        int                  cur_row;
        int                  cur_col;
        bit [7:0]            text_attr;
        tcce_pkg::t_out_item expected_q[$];
        int                  errors;
        int                  accepted;
        int                  scrolls;
        int                  reads;
        int                  clears;

        function new();
            cur_row   = 0;
            cur_col   = 0;
            text_attr = tcce_pkg::TEXT_ATTR_RESET;
            errors    = 0;
            accepted  = 0;
            scrolls   = 0;
            reads     = 0;
            clears    = 0;
            foreach (cell_written[k]) cell_written[k] = 1'b0;
        endfunction

        // Linear index of a position, clamped to the screen.
        function int cell_of(logic [4:0] row, logic [6:0] col);
            int r;
            int c;
            r = (row >= ROWS) ? ROWS - 1 : int'(row);
            c = (col >= COLS) ? COLS - 1 : int'(col);
            return r * COLS + c;
        endfunction

        function bit is_written(logic [4:0] row, logic [6:0] col);
            return cell_written[cell_of(row, col)];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_attribute(bit [7:0] attr);
            text_attr = attr;
        endfunction

        // Applies one accepted request to the shadow console and queues its result.
        function void note_request(tcce_pkg::t_in_item it);
            tcce_pkg::t_out_item res;
            int                  idx;
            int                  k;
            bit [15:0]           blank;

            res      = '0;
            idx      = cell_of(it.row, it.col);
            blank    = {text_attr, tcce_pkg::CH_SPACE};
            accepted++;
            case (it.operation)
                tcce_pkg::OP_PUT_CHAR: begin
                    if (it.char_code == tcce_pkg::CH_NEWLINE) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (it.char_code == tcce_pkg::CH_RETURN) begin
                        cur_col = 0;
                    end else if (it.char_code == tcce_pkg::CH_BACKSPACE) begin
                        // At column zero a backspace does nothing.
                        if (cur_col > 0) begin
                            cur_col--;
                            cells[cur_row * COLS + cur_col]        = blank;
                            cell_written[cur_row * COLS + cur_col] = 1'b1;
                        end
                    end else if (it.char_code == tcce_pkg::CH_TAB) begin
                        cur_col = cur_col + TAB - cur_col % TAB;
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end else begin
                        cells[cur_row * COLS + cur_col]        = {text_attr, it.char_code};
                        cell_written[cur_row * COLS + cur_col] = 1'b1;
                        cur_col++;
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    // Past the bottom line the screen moves up and the last line is blanked.
                    if (cur_row >= ROWS) begin
                        for (k = 0; k < CELL_COUNT - COLS; k++) begin
                            cells[k]        = cells[k + COLS];
                            cell_written[k] = cell_written[k + COLS];
                        end
                        for (k = CELL_COUNT - COLS; k < CELL_COUNT; k++) begin
                            cells[k]        = blank;
                            cell_written[k] = 1'b1;
                        end
                        cur_row      = ROWS - 1;
                        res.scrolled = 1'b1;
                        scrolls++;
                    end
                end
                tcce_pkg::OP_CLEAR: begin
                    for (k = 0; k < CELL_COUNT; k++) begin
                        cells[k]        = blank;
                        cell_written[k] = 1'b1;
                    end
                    cur_row = 0;
                    cur_col = 0;
                    clears++;
                end
                tcce_pkg::OP_SET_POSITION: begin
                    cur_row = idx / COLS;
                    cur_col = idx % COLS;
                end
                tcce_pkg::OP_WRITE_AT: begin
                    cells[idx]        = {it.cell_attr, it.char_code};
                    cell_written[idx] = 1'b1;
                end
                tcce_pkg::OP_READ_CELL: begin
                    res.read_char = cells[idx][7:0];
                    res.read_attr = cells[idx][15:8];
                    reads++;
                end
                default: begin
                end
            endcase
            res.cursor_row    = 5'(cur_row);
            res.cursor_col    = 7'(cur_col);
            res.cursor_offset = 11'(cur_row * COLS + cur_col);
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Compares one accepted result with the oldest outstanding expectation.
        function void check_result(tcce_pkg::t_out_item got);
            tcce_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request outstanding: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
            compare_field("cursor_offset", 16'(want.cursor_offset), 16'(got.cursor_offset));
            compare_field("read_char", 16'(want.read_char), 16'(got.read_char));
            compare_field("read_attr", 16'(want.read_attr), 16'(got.read_attr));
            compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
        endfunction
    endclass

    console_scoreboard sb;

    text_console_character_engine_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Idle time before the next transfer: mostly random, now and then a run with no gaps.
    function automatic int draw_gap(ref int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            run_left = int'($urandom_range(10, 40));
            return 0;
        end
        return int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic tcce_pkg::t_in_item make_request(logic [2:0] op, logic [7:0] ch,
                                                        logic [4:0] row, logic [6:0] col,
                                                        logic [7:0] attr);
        tcce_pkg::t_in_item it;
        it.operation = op;
        it.char_code = ch;
        it.row       = row;
        it.col       = col;
        it.cell_attr = attr;
        return it;
    endfunction

    // Random request, weighted towards text output with the control characters mixed in.
    function automatic tcce_pkg::t_in_item random_request();
        tcce_pkg::t_in_item it;
        int                 sel;
        int                 pick;
        int                 k;
        bit                 found;

        it.char_code = 8'($urandom_range(0, 255));
        it.row       = 5'($urandom_range(0, 31));
        it.col       = 7'($urandom_range(0, 127));
        it.cell_attr = 8'($urandom_range(0, 255));
        sel          = int'($urandom_range(0, 99));
        if (sel < 55) begin
            it.operation = tcce_pkg::OP_PUT_CHAR;
            pick = int'($urandom_range(0, 99));
            if (pick < 8)       it.char_code = tcce_pkg::CH_NEWLINE;
            else if (pick < 13) it.char_code = tcce_pkg::CH_RETURN;
            else if (pick < 20) it.char_code = tcce_pkg::CH_BACKSPACE;
            else if (pick < 27) it.char_code = tcce_pkg::CH_TAB;
        end else if (sel < 57) begin
            it.operation = tcce_pkg::OP_CLEAR;
        end else if (sel < 67) begin
            it.operation = tcce_pkg::OP_SET_POSITION;
            if ($urandom_range(0, 1) == 0) begin
                it.row = 5'($urandom_range(0, ROWS - 1));
                it.col = 7'($urandom_range(0, COLS - 1));
            end
        end else if (sel < 79) begin
            it.operation = tcce_pkg::OP_WRITE_AT;
        end else if (sel < 96) begin
            // Only cells that have been written may be read back.
            it.operation = tcce_pkg::OP_READ_CELL;
            found = sb.is_written(it.row, it.col);
            for (k = 0; k < 16 && !found; k++) begin
                it.row = 5'($urandom_range(0, 31));
                it.col = 7'($urandom_range(0, 127));
                found  = sb.is_written(it.row, it.col);
            end
            if (!found) it.operation = tcce_pkg::OP_WRITE_AT;
        end else begin
            it.operation = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        end
        return it;
    endfunction

    // Presents one request and waits for it to be taken.
    task automatic send_request(input tcce_pkg::t_in_item it);
        int gap;
        gap = draw_gap(src_run);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(it);
    endtask

    // Lets every outstanding result arrive with no new requests presented.
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] attr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= attr;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_attribute(attr);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, every result checked on acceptance.
    initial begin
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(sink_run);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_item);
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("text_console_character_engine_unit test failed");
        $finish;
    end

    // Main sequence: reset, directed cases, then random phases under different attributes.
    initial begin
        logic [7:0] attr;
        int         phase;
        int         n;

        sb          = new();
        src_run     = 0;
        sink_run    = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset attribute.
        send_request(make_request(tcce_pkg::OP_WRITE_AT, 8'h00, 5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_READ_CELL, 8'hFF, 5'd0, 7'd0, 8'hFF));
        // Out-of-range positions land on the last cell.
        send_request(make_request(tcce_pkg::OP_WRITE_AT, 8'hFF, 5'd31, 7'd127, 8'hFF));
        send_request(make_request(tcce_pkg::OP_READ_CELL, 8'h00, 5'd24, 7'd79, 8'h00));
        send_request(make_request(tcce_pkg::OP_READ_CELL, 8'h00, 5'd30, 7'd100, 8'h00));
        send_request(make_request(tcce_pkg::OP_SET_POSITION, 8'h00, 5'd31, 7'd127, 8'h00));
        // A character in the last cell wraps and scrolls.
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, 8'h41, 5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_READ_CELL, 8'h00, 5'd23, 7'd79, 8'h00));
        send_request(make_request(tcce_pkg::OP_READ_CELL, 8'h00, 5'd24, 7'd0, 8'h00));
        // Newline on the bottom row scrolls again.
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_NEWLINE,
                                  5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_BACKSPACE,
                                  5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, 8'h78, 5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_BACKSPACE,
                                  5'd0, 7'd0, 8'h00));
        // Tab that reaches the line end and one that stops inside the line.
        send_request(make_request(tcce_pkg::OP_SET_POSITION, 8'h00, 5'd5, 7'd75, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_TAB,
                                  5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_SET_POSITION, 8'h00, 5'd5, 7'd3, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_TAB,
                                  5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_RETURN,
                                  5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_CLEAR, 8'hFF, 5'd31, 7'd127, 8'hFF));
        send_request(make_request(tcce_pkg::OP_READ_CELL, 8'h00, 5'd12, 7'd40, 8'h00));
        send_request(make_request(OP_RESERVED_LO, 8'hFF, 5'd31, 7'd127, 8'hFF));
        send_request(make_request(OP_RESERVED_HI, 8'h00, 5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, 8'hFF, 5'd0, 7'd0, 8'h00));
        send_request(make_request(tcce_pkg::OP_SET_POSITION, 8'h00, 5'd24, 7'd79, 8'h00));
        send_request(make_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_TAB,
                                  5'd0, 7'd0, 8'h00));
        settle_idle();

        // Random phases, each under its own attribute, extremes first.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0)      attr = 8'h00;
            else if (phase == 1) attr = 8'hFF;
            else                 attr = 8'($urandom_range(0, 255));
            write_attribute(attr);
            for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
            settle_idle();
        end

        $display("Covered %0d requests over %0d attribute settings,", sb.accepted,
                 PHASE_COUNT + 1);
        $display("including %0d cell reads, %0d scrolls and %0d screen clears.",
                 sb.reads, sb.scrolls, sb.clears);
        if (sb.errors == 0) begin
            $display("text_console_character_engine_unit test passed");
        end else begin
            $display("text_console_character_engine_unit test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tcce_pkg.sv
hdl/tcce_ram.sv
hdl/tcce_front.sv
hdl/tcce_queue.sv
hdl/tcce_back.sv
hdl/text_console_character_engine_unit.sv
tb/tb_text_console_character_engine_unit.sv
